/* rtl/core/r2rc_pkg.sv */
// shared types and constants for the rigid 2-d registration cost block
`timescale 1ns / 1ps
`default_nettype none
package r2rc_pkg;
  typedef enum logic [1:0] {
    REQ_LOAD_REF = 2'd0,
    REQ_LOAD_CUR = 2'd1,
    REQ_SET_FLAG = 2'd2,
    REQ_EVALUATE = 2'd3
  } req_e;

  localparam logic [1:0] REG_SLICES = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_COLS   = 2'd2;

  localparam int unsigned MinPoints = 10;
  localparam logic [47:0] MeanMax = '1;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [14:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

/* rtl/core/r2rc_div.sv */
// restoring divider, one quotient bit per cycle, saturating to 48 bits
`timescale 1ns / 1ps
`default_nettype none
module r2rc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  r2rc_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [47:0]         quot_o
);
  import r2rc_pkg::*;

  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [15:0] trial;

  always_comb begin
    trial = {rem_q[14:0], num_q[63]};
    rem_d = trial;
    quo_d = {quo_q[62:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
    num_d = {num_q[62:0], 1'b0};
  end

  // done stays high until the next start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
        done_o <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = (quo_q[63:48] != '0) ? MeanMax : quo_q[47:0];
endmodule
`default_nettype wire

/* rtl/core/rigid_2d_registration_cost.sv */
// top level: image stores, grid walker, shared multiplier and mean divider
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | request fields
//  out     | out | out_valid/out_ready| mean, count, too-few flag
//  cfg     | in  | apb psel/penable   | slices, rows, cols
// loads and flag writes leave the block in idle, ready for the next request
// an evaluate walks each enabled slice and its grid points; a point whose rotated position
// falls outside the image is skipped, a compared point is read and weighted through one shared
// multiplier and the memory read port, then the sum is divided by the point count
// reset clears the flags and sets the geometry registers to their maximums; stores are not cleared
// a finished result is held in the output register while the next request is taken
// the next result waits until the held one has been taken
`timescale 1ns / 1ps
`default_nettype none
module rigid_2d_registration_cost #(
  parameter int MAX_SLICES = 16,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int GRID_STEP  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  slice_index_i,
  input  logic [5:0]  row_index_i,
  input  logic [5:0]  col_index_i,
  input  logic signed [15:0] pixel_value_i,
  input  logic        slice_used_i,
  input  logic signed [14:0] shift_row_i,
  input  logic signed [14:0] shift_col_i,
  input  logic signed [15:0] rot_cos_i,
  input  logic signed [15:0] rot_sin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] mean_sq_diff_o,
  output logic [14:0] point_count_o,
  output logic        too_few_points_o
);
  import r2rc_pkg::*;

  localparam int SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = SW + RW + CW;
  localparam int Depth = MAX_SLICES * MAX_ROWS * MAX_COLS;

  logic signed [15:0] ref_mem [Depth];
  logic signed [15:0] cur_mem [Depth];
  logic [MAX_SLICES-1:0] flags_q;
  logic [4:0] slices_q;
  logic [6:0] rows_q, cols_q;

  // config
  logic cfg_wr;
  logic [6:0] wv7;
  logic [4:0] wv5;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wv7 = pwdata[6:0];
  assign wv5 = pwdata[4:0];
  always_comb begin
    case (paddr[3:2])
      REG_SLICES: prdata = {27'd0, slices_q};
      REG_ROWS:   prdata = {25'd0, rows_q};
      REG_COLS:   prdata = {25'd0, cols_q};
      default:    prdata = '0;
    endcase
  end

  typedef enum logic [4:0] {
    S_IDLE, S_SLICE, S_POINT, S_M0, S_M1, S_M2, S_M3, S_CHK, S_RD0, S_RD1,
    S_RD2, S_RD3, S_W0, S_P0, S_W1, S_P1, S_W2, S_P2, S_W3, S_P3, S_DIFF, S_SQ,
    S_ACC, S_NEXT, S_DIV, S_WAIT
  } state_e;
  state_e state_q;

  logic [SW:0] b_q;
  logic [7:0] r_q, c_q;
  logic signed [14:0] tr_q, tc_q;
  logic signed [15:0] cs_q, sn_q;
  logic signed [35:0] rp_q, cp_q;
  logic [63:0] sum_q;
  logic [15:0] cnt_q;
  logic signed [15:0] p0_q, p1_q, p2_q, p3_q, u_q;
  logic signed [50:0] v_q;
  logic signed [32:0] wp_q;
  logic [AW-1:0] raddr;
  logic signed [15:0] rdc_q, rdr_q;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [65:0] mp_q;
  assign mp = ma * mb;

  logic [15:0] w_r1, w_r2, w_c1, w_c2;
  logic [20:0] rr, cc;
  assign w_r1 = {2'b0, rp_q[13:0]};
  assign w_c1 = {2'b0, cp_q[13:0]};
  assign w_r2 = 16'd16384 - w_r1;
  assign w_c2 = 16'd16384 - w_c1;
  assign rr = rp_q[34:14];
  assign cc = cp_q[34:14];

  logic signed [51:0] dnum;
  logic signed [31:0] d_q;
  assign dnum = ($signed({{8{u_q[15]}}, u_q, 28'd0}) - 52'(v_q)) + 52'sd524288;

  logic [64:0] acc_sum;
  assign acc_sum = {1'b0, sum_q} + {1'b0, mp_q[63:0]};

  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      S_M0: begin ma = 33'(cs_q); mb = 33'($signed({1'b0, r_q})); end
      S_M1: begin ma = 33'(sn_q); mb = 33'($signed({1'b0, c_q})); end
      S_M2: begin ma = 33'(sn_q); mb = 33'($signed({1'b0, r_q})); end
      S_M3: begin ma = 33'(cs_q); mb = 33'($signed({1'b0, c_q})); end
      S_W0: begin ma = 33'($signed({1'b0, w_r2})); mb = 33'($signed({1'b0, w_c2})); end
      S_W1: begin ma = 33'($signed({1'b0, w_r2})); mb = 33'($signed({1'b0, w_c1})); end
      S_W2: begin ma = 33'($signed({1'b0, w_r1})); mb = 33'($signed({1'b0, w_c2})); end
      S_W3: begin ma = 33'($signed({1'b0, w_r1})); mb = 33'($signed({1'b0, w_c1})); end
      S_P0: begin ma = wp_q; mb = 33'(p0_q); end
      S_P1: begin ma = wp_q; mb = 33'(p1_q); end
      S_P2: begin ma = wp_q; mb = 33'(p2_q); end
      S_P3: begin ma = wp_q; mb = 33'(p3_q); end
      S_SQ: begin ma = 33'(d_q); mb = 33'(d_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [SW-1:0] bi;
  assign bi = b_q[SW-1:0];
  always_comb begin
    case (state_q)
      S_CHK:   raddr = {bi, rr[RW-1:0], cc[CW-1:0]};
      S_RD0:   raddr = {bi, rr[RW-1:0], CW'(cc + 21'd1)};
      S_RD1:   raddr = {bi, RW'(rr + 21'd1), cc[CW-1:0]};
      default: raddr = {bi, RW'(rr + 21'd1), CW'(cc + 21'd1)};
    endcase
  end

  logic in_acc, out_acc, ld_ok;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign ld_ok = (32'(slice_index_i) < MAX_SLICES) && (32'(row_index_i) < MAX_ROWS)
                 && (32'(col_index_i) < MAX_COLS);

  logic [AW-1:0] waddr;
  assign waddr = {SW'(slice_index_i), RW'(row_index_i), CW'(col_index_i)};
  always_ff @(posedge clk_i) begin
    if (in_acc && ld_ok && req_type_i == REQ_LOAD_REF) ref_mem[waddr] <= pixel_value_i;
    if (in_acc && ld_ok && req_type_i == REQ_LOAD_CUR) cur_mem[waddr] <= pixel_value_i;
    rdc_q <= cur_mem[raddr];
    rdr_q <= ref_mem[{bi, RW'(r_q), CW'(c_q)}];
  end

  div_req_t dreq;
  logic ddone;
  logic [47:0] dquot;
  r2rc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));
  always_comb begin
    dreq.start = (state_q == S_DIV);
    dreq.dividend = sum_q;
    dreq.divisor = (cnt_q > 16'h7FFF) ? 15'h7FFF : cnt_q[14:0];
  end

  logic res_load;
  assign res_load = (state_q == S_WAIT) && ddone && (!out_valid_o || out_acc);

  logic [7:0] q0;
  assign q0 = {7'd0, b_q[0]} + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flags_q <= '0;
      slices_q <= 5'(MAX_SLICES);
      rows_q <= 7'(MAX_ROWS);
      cols_q <= 7'(MAX_COLS);
      out_valid_o <= 1'b0;
      sum_q <= '0;
      cnt_q <= '0;
      b_q <= '0;
    end else begin
      if (out_acc && !res_load) out_valid_o <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_SLICES: slices_q <= (32'(wv5) > MAX_SLICES) ? 5'(MAX_SLICES) : wv5;
          REG_ROWS:   rows_q <= (32'(wv7) > MAX_ROWS) ? 7'(MAX_ROWS) : wv7;
          REG_COLS:   cols_q <= (32'(wv7) > MAX_COLS) ? 7'(MAX_COLS) : wv7;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (in_acc) begin
          if (req_type_i == REQ_SET_FLAG && 32'(slice_index_i) < MAX_SLICES)
            flags_q[SW'(slice_index_i)] <= slice_used_i;
          if (req_type_i == REQ_EVALUATE) begin
            tr_q <= shift_row_i; tc_q <= shift_col_i;
            cs_q <= rot_cos_i; sn_q <= rot_sin_i;
            sum_q <= '0; cnt_q <= '0; b_q <= '0;
            state_q <= S_SLICE;
          end
        end
        S_SLICE: begin
          if ({3'd0, b_q} >= 8'(slices_q) || 32'(b_q) >= MAX_SLICES) state_q <= S_DIV;
          else if (!flags_q[bi] || {1'b0, q0} + 9'd1 >= {2'b0, rows_q}
                   || {1'b0, q0} + 9'd1 >= {2'b0, cols_q}) b_q <= b_q + 1'b1;
          else begin
            r_q <= q0; c_q <= q0; state_q <= S_M0;
          end
        end
        S_M0: begin rp_q <= 36'($signed({tr_q, 6'd0})) + 36'(mp); state_q <= S_M1; end
        S_M1: begin rp_q <= rp_q - 36'(mp); state_q <= S_M2; end
        S_M2: begin cp_q <= 36'($signed({tc_q, 6'd0})) + 36'(mp); state_q <= S_M3; end
        S_M3: begin cp_q <= cp_q + 36'(mp); state_q <= S_CHK; end
        S_CHK: begin
          if (rp_q[35] || cp_q[35] || rr + 21'd2 >= 21'(rows_q)
              || cc + 21'd2 >= 21'(cols_q)) state_q <= S_NEXT;
          else state_q <= S_RD0;
        end
        S_RD0: begin p0_q <= rdc_q; u_q <= rdr_q; state_q <= S_RD1; end
        S_RD1: begin p1_q <= rdc_q; state_q <= S_RD2; end
        S_RD2: begin p2_q <= rdc_q; state_q <= S_RD3; end
        S_RD3: begin p3_q <= rdc_q; v_q <= '0; state_q <= S_W0; end
        S_W0: begin wp_q <= mp[32:0]; state_q <= S_P0; end
        S_P0: begin v_q <= v_q + 51'(mp); state_q <= S_W1; end
        S_W1: begin wp_q <= mp[32:0]; state_q <= S_P1; end
        S_P1: begin v_q <= v_q + 51'(mp); state_q <= S_W2; end
        S_W2: begin wp_q <= mp[32:0]; state_q <= S_P2; end
        S_P2: begin v_q <= v_q + 51'(mp); state_q <= S_W3; end
        S_W3: begin wp_q <= mp[32:0]; state_q <= S_P3; end
        S_P3: begin v_q <= v_q + 51'(mp); state_q <= S_DIFF; end
        S_DIFF: begin d_q <= 32'(dnum >>> 20); state_q <= S_SQ; end
        S_SQ: begin mp_q <= mp; state_q <= S_ACC; end
        S_ACC: begin
          sum_q <= acc_sum[64] ? '1 : acc_sum[63:0];
          if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (c_q + 8'(GRID_STEP) + 8'd1 < {1'b0, cols_q}) begin
            c_q <= c_q + 8'(GRID_STEP); state_q <= S_M0;
          end else if (r_q + 8'(GRID_STEP) + 8'd1 < {1'b0, rows_q}) begin
            r_q <= r_q + 8'(GRID_STEP); c_q <= q0; state_q <= S_M0;
          end else begin
            b_q <= b_q + 1'b1; state_q <= S_SLICE;
          end
        end
        S_DIV: state_q <= S_WAIT;
        S_WAIT: if (res_load) begin
          out_valid_o <= 1'b1;
          point_count_o <= (cnt_q > 16'h7FFF) ? 15'h7FFF : cnt_q[14:0];
          too_few_points_o <= (cnt_q < 16'(MinPoints));
          mean_sq_diff_o <= (cnt_q < 16'(MinPoints)) ? MeanMax : dquot;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_few_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_few_points_o) |-> mean_sq_diff_o == MeanMax)
    else $error("too few without max mean");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(mean_sq_diff_o))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

/* dv/rigid_2d_registration_cost_test.sv */
// self-checking testbench for the rigid 2-d registration cost block
`timescale 1ns / 1ps
module rigid_2d_registration_cost_test;
  import r2rc_pkg::*;

  localparam int unsigned StallLimit = 100000;
  localparam int unsigned HoldCycles = 5000;

  typedef struct {
    req_e              kind;
    logic [3:0]        sl;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [15:0] pix;
    logic              used;
    logic signed [14:0] tr;
    logic signed [14:0] tc;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } req_item_t;

  typedef struct {
    logic [47:0] mean;
    logic [14:0] count;
    logic        few;
  } cost_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type = '0;
  logic [3:0] slice_index = '0;
  logic [5:0] row_index = '0, col_index = '0;
  logic signed [15:0] pixel_value = '0;
  logic slice_used = 1'b0;
  logic signed [14:0] shift_row = '0, shift_col = '0;
  logic signed [15:0] rot_cos = '0, rot_sin = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic [47:0] mean_sq_diff_o;
  logic [14:0] point_count_o;
  logic too_few_points_o;

  rigid_2d_registration_cost DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_ready_o,
    .req_type_i(req_type), .slice_index_i(slice_index), .row_index_i(row_index),
    .col_index_i(col_index), .pixel_value_i(pixel_value), .slice_used_i(slice_used),
    .shift_row_i(shift_row), .shift_col_i(shift_col),
    .rot_cos_i(rot_cos), .rot_sin_i(rot_sin),
    .out_valid_o, .out_ready_i(out_ready),
    .mean_sq_diff_o, .point_count_o, .too_few_points_o
  );

  logic signed [15:0] ref_img [65536];
  logic signed [15:0] cur_img [65536];
  bit slice_on [16];
  int unsigned slices_cfg, rows_cfg, cols_cfg;

  req_item_t pending [$];
  cost_t costs_due [$];
  req_item_t cur_item;
  bit in_taken = 0;
  int unsigned in_gap = 0, out_stall = 0, hold_left = 0;
  bit hold_trigger = 0, fast_in = 1, fast_out = 1;
  int unsigned idle_cycles = 0;
  int errors = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int img_idx(longint b, longint r, longint c);
    return int'((b * 64 + r) * 64 + c);
  endfunction

  function automatic cost_t registration_cost(req_item_t it);
    cost_t res;
    longint nr, nc, rp, cp, rr, cc, r1, r2, c1, c2, v, u, d;
    longint unsigned sum, sq, mean;
    int unsigned cnt;
    int i0, i1;
    nr = rows_cfg;
    nc = cols_cfg;
    sum = 0;
    cnt = 0;
    for (int b = 0; b < slices_cfg; b++) begin
      if (!slice_on[b]) continue;
      for (longint r = (b & 1) + 1; r < nr - 1; r += 2) begin
        for (longint c = (b & 1) + 1; c < nc - 1; c += 2) begin
          rp = longint'(it.cs) * r - longint'(it.sn) * c + longint'(it.tr) * 64;
          cp = longint'(it.sn) * r + longint'(it.cs) * c + longint'(it.tc) * 64;
          if (rp < 0 || cp < 0) continue;
          rr = rp >>> 14;
          cc = cp >>> 14;
          if (rr + 1 >= nr - 1 || cc + 1 >= nc - 1) continue;
          r1 = rp & 16383;
          r2 = 16384 - r1;
          c1 = cp & 16383;
          c2 = 16384 - c1;
          i0 = img_idx(b, rr, cc);
          i1 = img_idx(b, rr + 1, cc);
          v = r2 * c2 * longint'(cur_img[i0]) + r2 * c1 * longint'(cur_img[i0 + 1])
            + r1 * c2 * longint'(cur_img[i1]) + r1 * c1 * longint'(cur_img[i1 + 1]);
          u = longint'(ref_img[img_idx(b, r, c)]);
          d = ((u <<< 28) - v + (longint'(1) <<< 19)) >>> 20;
          sq = longint'(d * d);
          sum = (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
          cnt++;
        end
      end
    end
    if (cnt < MinPoints) begin
      res.mean = MeanMax;
      res.few = 1'b1;
    end else begin
      mean = sum / cnt;
      res.mean = (mean > 64'(MeanMax)) ? MeanMax : mean[47:0];
      res.few = 1'b0;
    end
    res.count = (cnt > 32767) ? 15'h7fff : cnt[14:0];
    return res;
  endfunction

  function automatic void apply_item(req_item_t it);
    case (it.kind)
      REQ_LOAD_REF: ref_img[img_idx(it.sl, it.row, it.col)] = it.pix;
      REQ_LOAD_CUR: cur_img[img_idx(it.sl, it.row, it.col)] = it.pix;
      REQ_SET_FLAG: slice_on[it.sl] = it.used;
      default: costs_due.push_back(registration_cost(it));
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic nv;
    nv = in_valid;
    if (in_taken) begin
      nv = 1'b0;
      in_taken = 0;
      in_gap = fast_in ? 0 : $urandom_range(0, 11);
    end
    if (!nv && rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending.size() > 0) begin
        cur_item = pending.pop_front();
        req_type <= cur_item.kind;
        slice_index <= cur_item.sl;
        row_index <= cur_item.row;
        col_index <= cur_item.col;
        pixel_value <= cur_item.pix;
        slice_used <= cur_item.used;
        shift_row <= cur_item.tr;
        shift_col <= cur_item.tc;
        rot_cos <= cur_item.cs;
        rot_sin <= cur_item.sn;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_trigger) begin
      hold_trigger = 0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni;
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk_i) begin
    cost_t exp_cost;
    idle_cycles++;
    if (in_valid && in_ready_o) begin
      apply_item(cur_item);
      in_taken = 1;
      idle_cycles = 0;
    end
    if (out_valid_o && out_ready) begin
      idle_cycles = 0;
      out_stall = fast_out ? 0 : $urandom_range(0, 11);
      if (costs_due.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_cost = costs_due.pop_front();
        if (mean_sq_diff_o !== exp_cost.mean) begin
          $error("mean_sq_diff expected %0d actual %0d", exp_cost.mean, mean_sq_diff_o);
          errors++;
        end
        if (point_count_o !== exp_cost.count) begin
          $error("point_count expected %0d actual %0d", exp_cost.count, point_count_o);
          errors++;
        end
        if (too_few_points_o !== exp_cost.few) begin
          $error("too_few_points expected %0d actual %0d", exp_cost.few, too_few_points_o);
          errors++;
        end
      end
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SLICES: slices_cfg = ((val & 31) > 16) ? 16 : (val & 31);
      REG_ROWS: rows_cfg = ((val & 127) > 64) ? 64 : (val & 127);
      default: cols_cfg = ((val & 127) > 64) ? 64 : (val & 127);
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || in_taken || costs_due.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned s, int unsigned r, int unsigned c);
    cfg_write(REG_SLICES, s);
    cfg_write(REG_ROWS, r);
    cfg_write(REG_COLS, c);
  endtask

  function automatic req_item_t pixel_load(req_e k, int b, int r, int c, int p);
    req_item_t it;
    it = '{kind: k, sl: 4'(b), row: 6'(r), col: 6'(c), pix: 16'(p), used: 1'($urandom),
           tr: 15'($urandom), tc: 15'($urandom), cs: 16'($urandom), sn: 16'($urandom)};
    return it;
  endfunction

  function automatic req_item_t flag_item(int b, bit on);
    req_item_t it;
    it = pixel_load(REQ_SET_FLAG, b, $urandom, $urandom, $urandom);
    it.used = on;
    return it;
  endfunction

  function automatic req_item_t eval_item(int tr, int tc, int cs, int sn);
    req_item_t it;
    it = pixel_load(REQ_EVALUATE, $urandom, $urandom, $urandom, $urandom);
    it.tr = 15'(tr);
    it.tc = 15'(tc);
    it.cs = 16'(cs);
    it.sn = 16'(sn);
    return it;
  endfunction

  function automatic req_item_t random_eval();
    if ($urandom_range(0, 9) < 7)
      return eval_item(int'($urandom_range(0, 1024)) - 512, int'($urandom_range(0, 1024)) - 512,
                       16384 - int'($urandom_range(0, 300)), int'($urandom_range(0, 600)) - 300);
    return eval_item(int'($urandom_range(0, 32767)) - 16384,
                     int'($urandom_range(0, 32767)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    int unsigned eval_cap, evals, s, r, c, pick, fb;
    slices_cfg = 16;
    rows_cfg = 64;
    cols_cfg = 64;
    foreach (slice_on[i]) slice_on[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the region that evaluations can reach: slices 0 to 3, rows and columns 0 to 7
    // only these slices are on in evaluations, and with one on the size is 9 or less
    for (int b = 0; b < 4; b++)
      for (int y = 0; y < 8; y++)
        for (int x = 0; x < 8; x++) begin
          pending.push_back(pixel_load(REQ_LOAD_REF, b, y, x, $urandom));
          pending.push_back(pixel_load(REQ_LOAD_CUR, b, y, x, $urandom));
        end
    wait_idle();

    // directed
    set_geometry(4, 9, 9);
    pending.push_back(pixel_load(REQ_LOAD_REF, 0, 1, 1, 32767));
    pending.push_back(pixel_load(REQ_LOAD_CUR, 0, 1, 1, -32768));
    pending.push_back(pixel_load(REQ_LOAD_REF, 1, 2, 2, -32768));
    pending.push_back(pixel_load(REQ_LOAD_CUR, 1, 2, 3, 32767));
    pending.push_back(eval_item(0, 0, 16384, 0));
    pending.push_back(flag_item(0, 1));
    pending.push_back(flag_item(1, 1));
    pending.push_back(flag_item(15, 1));
    pending.push_back(flag_item(15, 0));
    pending.push_back(eval_item(0, 0, 16384, 0));
    pending.push_back(eval_item(128, 64, 16384, 0));
    pending.push_back(eval_item(-512, 0, 16384, 0));
    pending.push_back(eval_item(0, -300, 16384, 0));
    pending.push_back(eval_item(16383, 16383, 16384, 0));
    pending.push_back(eval_item(-16384, -16384, 16384, 0));
    pending.push_back(eval_item(2560, 2560, -16384, 0));
    pending.push_back(eval_item(0, 2560, 0, 16384));
    pending.push_back(eval_item(2560, 0, 0, -16384));
    pending.push_back(eval_item(77, 200, 16300, 1200));
    pending.push_back(eval_item(0, 0, -16384, -16384));
    wait_idle();

    // random phases over several geometries
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin s = 1; r = 3; c = 3; end
        1: begin s = 16; r = 9; c = 9; end
        2: begin s = 31; r = 9; c = 8; end
        3: begin s = 0; r = 8; c = 8; end
        4: begin s = 5; r = 127; c = 6; end
        5: begin s = 16; r = 2; c = 9; end
        default: begin
          s = $urandom_range(1, 16);
          r = $urandom_range(3, 9);
          c = $urandom_range(3, 9);
        end
      endcase
      set_geometry(s, r, c);
      eval_cap = (ph == 1) ? 1 : 40;
      evals = 0;
      fast_in = ($urandom_range(0, 2) == 0);
      fast_out = ($urandom_range(0, 2) == 0);
      if (ph == 2) begin
        fast_in = 1;
        hold_trigger = 1;
      end
      // slices 0 to 3 on in phase 1, all off in phase 4 where rows pass the filled region
      if (ph == 1 || ph == 4) begin
        for (int b = 0; b < 16; b++) pending.push_back(flag_item(b, ph == 1 && b < 4));
      end
      for (int n = 0; n < 120; n++) begin
        pick = $urandom_range(0, 99);
        if ((ph == 1 || ph == 4) && n < 110 && pick >= 12 && pick < 20) pick = 50;
        if ((pick < 8 || (ph == 2 && pick < 30)) && evals < eval_cap) begin
          pending.push_back(random_eval());
          evals++;
        end else if (pick < 20 && ph != 1 && ph != 4) begin
          fb = $urandom_range(0, 15);
          pending.push_back(flag_item(fb, (fb < 4) && ($urandom_range(0, 1) == 1)));
        end else begin
          pending.push_back(pixel_load(pick[0] ? REQ_LOAD_CUR : REQ_LOAD_REF,
                                       $urandom, $urandom, $urandom, $urandom));
        end
      end
      wait_idle();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
